>>> sv/bvsa_pkg.sv
// Package for the barometric vertical speed averager.
// Holds field widths, arithmetic constants, controller states and the
// command and status structs. No dependencies.
`default_nettype none

package bvsa_pkg;

  // Field widths of the input and result beats.
  localparam int ALT_W  = 22;
  localparam int DIFF_W = 23;
  localparam int EL_W   = 16;
  localparam int VS_W   = 18;
  localparam int DB_W   = 10;

  // Deadband register reset value in cm/s.
  localparam logic [DB_W-1:0] DB_RESET = DB_W'(10);

  // Climb rate: signed cm/s, saturated to plus or minus RATE_LIMIT.
  localparam int RATE_W     = 17;
  localparam int RMAG_W     = 16;
  localparam int RATE_LIMIT = 50000;

  // Altitude change magnitude and the scale to ms.
  localparam int DMAG_W = DIFF_W - 1;
  localparam int SCALE  = 1000;
  localparam int DVD_W  = 32;
  localparam int CNT_W  = $clog2(DVD_W);

  // Conversion from cm/s to ft/min in Q16.
  localparam int FPM_MULT  = 129009;
  localparam int FPM_W     = 17;
  localparam int FPM_SHIFT = 16;
  localparam int PROD_W    = RMAG_W + FPM_W;

  // Averaging ring; the depth must be a power of two.
  localparam int AVG_DEPTH = 8;
  localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
  localparam int PTR_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W     = RATE_W + AVG_SHIFT;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RATE,
    ST_ACC,
    ST_SCALE,
    ST_EMIT
  } bvsa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prime;
    logic mul;
    logic div_start;
    logic rate;
    logic acc;
    logic scale;
    logic load_out;
  } bvsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic div_done;
  } bvsa_sts_t;

endpackage

`default_nettype wire

>>> sv/bvsa_in_if.sv
// Input channel of the vertical speed averager: valid, ready and one sample.
// Depends on bvsa_pkg for the field widths.
`default_nettype none

interface bvsa_in_if
  import bvsa_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ALT_W-1:0]  pressure_alt_cm;
  logic signed [ALT_W-1:0]  gps_alt_cm;
  logic        [EL_W-1:0]   elapsed_ms;

  modport source (output valid, pressure_alt_cm, gps_alt_cm, elapsed_ms, input ready);
  modport sink   (input valid, pressure_alt_cm, gps_alt_cm, elapsed_ms, output ready);
endinterface

`default_nettype wire

>>> sv/bvsa_out_if.sv
// Result channel of the vertical speed averager: valid, ready and one result.
// Depends on bvsa_pkg for the field widths.
`default_nettype none

interface bvsa_out_if
  import bvsa_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ALT_W-1:0]  alt_out_cm;
  logic signed [DIFF_W-1:0] alt_diff_cm;
  logic signed [VS_W-1:0]   vs_fpm;
  logic                     primed;

  modport source (output valid, alt_out_cm, alt_diff_cm, vs_fpm, primed, input ready);
  modport sink   (input valid, alt_out_cm, alt_diff_cm, vs_fpm, primed, output ready);
endinterface

`default_nettype wire

>>> sv/baro_vertical_speed_averager.sv
// Barometric vertical speed averager: the controller and the datapath.
// Depends on bvsa_pkg, bvsa_in_if, bvsa_out_if, bvsa_ctrl and bvsa_dp.
//
// Each input beat carries a pressure altitude, a GPS altitude and the ms since
// the previous sample, and yields exactly one result beat. The first sample
// after reset only primes the previous altitude and clears the eight-entry
// rate ring (primed = 0, vs_fpm = 0). A later sample goes through the
// 32-step bit-serial divider that forms the climb rate in cm/s, and the next
// sample is accepted only once the current one has reached the result register.
// A result register sits on the output side, so a new sample is taken while a
// finished result still waits. The deadband register may only be written
// while no sample is in flight.
`default_nettype none

module baro_vertical_speed_averager
  import bvsa_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  bvsa_in_if.sink              in_i,
  bvsa_out_if.source           out_o,
  input  wire logic            cfg_we_i,
  input  wire logic [DB_W-1:0] cfg_data_i
);

  bvsa_cmd_t cmd;
  bvsa_sts_t sts;

  // Sequencer.
  bvsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  bvsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pressure_alt_cm_i (in_i.pressure_alt_cm),
    .gps_alt_cm_i      (in_i.gps_alt_cm),
    .elapsed_ms_i      (in_i.elapsed_ms),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .alt_out_cm_o      (out_o.alt_out_cm),
    .alt_diff_cm_o     (out_o.alt_diff_cm),
    .vs_fpm_o          (out_o.vs_fpm),
    .primed_o          (out_o.primed)
  );

endmodule

`default_nettype wire

>>> sv/bvsa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on bvsa_pkg for the dividend and divisor widths.
`default_nettype none

module bvsa_div
  import bvsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [EL_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [EL_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [EL_W:0]    rem_sh;
  logic [EL_W:0]    rem_sub;
  logic             fits;

  // One shift-subtract step: bring in the next dividend bit.
  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_i};
    fits    = (rem_sh >= {1'b0, divisor_i});
  end

  // Step counter and quotient shift register.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[EL_W-1:0] : rem_sh[EL_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> sv/bvsa_ctrl.sv
// Sequencing state machine of the vertical speed averager.
// Depends on bvsa_pkg for the state enum and the command and status structs.
`default_nettype none

module bvsa_ctrl
  import bvsa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire bvsa_sts_t sts_i,
  output bvsa_cmd_t      cmd_o
);

  bvsa_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_beat;
  logic        out_free;

  assign in_beat  = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.have_prev ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL:      state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_RATE;
        end
      end
      ST_RATE:     state_d = ST_ACC;
      ST_ACC:      state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = in_beat;
    cmd_o.prime     = in_beat && !sts_i.have_prev;
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.div_start = (state_q == ST_DIV_GO);
    cmd_o.rate      = (state_q == ST_RATE);
    cmd_o.acc       = (state_q == ST_ACC);
    cmd_o.scale     = (state_q == ST_SCALE);
    cmd_o.load_out  = (state_q == ST_EMIT) && out_free;
  end

  // Result valid: set when the output register loads, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/bvsa_dp.sv
// Datapath of the vertical speed averager: sample registers, rate divider,
// averaging ring with running sum, deadband, ft/min scaling and result register.
// Depends on bvsa_pkg and bvsa_div.
`default_nettype none

module bvsa_dp
  import bvsa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bvsa_cmd_t               cmd_i,
  output bvsa_sts_t                    sts_o,
  input  wire logic signed [ALT_W-1:0] pressure_alt_cm_i,
  input  wire logic signed [ALT_W-1:0] gps_alt_cm_i,
  input  wire logic        [EL_W-1:0]  elapsed_ms_i,
  input  wire logic                    cfg_we_i,
  input  wire logic        [DB_W-1:0]  cfg_data_i,
  output logic signed [ALT_W-1:0]      alt_out_cm_o,
  output logic signed [DIFF_W-1:0]     alt_diff_cm_o,
  output logic signed [VS_W-1:0]       vs_fpm_o,
  output logic                         primed_o
);

  // Persistent state.
  logic                     have_prev_q;
  logic signed [ALT_W-1:0]  prev_alt_q;
  logic [DB_W-1:0]          deadband_q;
  logic signed [RATE_W-1:0] ring_q [AVG_DEPTH];
  logic [PTR_W-1:0]         ptr_q;
  logic signed [SUM_W-1:0]  sum_q;

  // Per-sample working registers.
  logic signed [ALT_W-1:0]  alt_q;
  logic signed [DIFF_W-1:0] gdiff_q;
  logic signed [DIFF_W-1:0] delta_q;
  logic [EL_W-1:0]          el_q;
  logic                     prime_q;
  logic                     neg_q;
  logic [DVD_W-1:0]         dvd_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     vs_neg_q;

  // Result register.
  logic signed [ALT_W-1:0]  alt_out_q;
  logic signed [DIFF_W-1:0] diff_out_q;
  logic signed [VS_W-1:0]   vs_out_q;
  logic                     primed_out_q;

  logic                     div_done;
  logic [DVD_W-1:0]         quotient;
  logic [DMAG_W-1:0]        dmag;
  logic [RMAG_W-1:0]        rmag;
  logic [SUM_W-1:0]         sum_mag;
  logic [RMAG_W-1:0]        avg_mag;
  logic [RMAG_W-1:0]        avg_kept;
  logic [VS_W-1:0]          fpm_mag;
  logic signed [VS_W-1:0]   vs_val;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DB_RESET;
    end else if (cfg_we_i) begin
      deadband_q <= cfg_data_i;
    end
  end

  // Sample capture: the change against the previous altitude is formed here.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      alt_q   <= pressure_alt_cm_i;
      gdiff_q <= DIFF_W'(gps_alt_cm_i) - DIFF_W'(pressure_alt_cm_i);
      delta_q <= DIFF_W'(pressure_alt_cm_i) - DIFF_W'(prev_alt_q);
      el_q    <= (elapsed_ms_i == '0) ? EL_W'(1) : elapsed_ms_i;
      prime_q <= !have_prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_alt_q  <= '0;
    end else if (cmd_i.capture) begin
      have_prev_q <= 1'b1;
      prev_alt_q  <= pressure_alt_cm_i;
    end
  end

  // Magnitude of the change scaled to per-second units.
  assign dmag = delta_q[DIFF_W-1] ? DMAG_W'(-delta_q) : DMAG_W'(delta_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      neg_q <= delta_q[DIFF_W-1];
      dvd_q <= DVD_W'(dmag) * DVD_W'(SCALE);
    end
  end

  bvsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_q),
    .divisor_i  (el_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Saturate the quotient and restore the sign.
  assign rmag = (quotient > DVD_W'(RATE_LIMIT)) ? RMAG_W'(RATE_LIMIT)
                                                : quotient[RMAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate) begin
      rate_q <= neg_q ? -$signed(RATE_W'(rmag)) : $signed(RATE_W'(rmag));
    end
  end

  // Averaging ring and running sum; a priming sample clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      ptr_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.prime) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      ptr_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      ring_q[ptr_q] <= rate_q;
      sum_q         <= sum_q + SUM_W'(rate_q) - SUM_W'(ring_q[ptr_q]);
      ptr_q         <= (ptr_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
    end
  end

  // Mean magnitude, truncated toward zero, then the deadband.
  assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign avg_mag  = RMAG_W'(sum_mag >> AVG_SHIFT);
  assign avg_kept = (avg_mag < RMAG_W'(deadband_q)) ? '0 : avg_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      vs_neg_q <= sum_q[SUM_W-1];
      prod_q   <= PROD_W'(avg_kept) * PROD_W'(FPM_MULT);
    end
  end

  // Scaled magnitude back to a signed ft/min value.
  assign fpm_mag = VS_W'(prod_q >> FPM_SHIFT);
  assign vs_val  = prime_q  ? '0 :
                   vs_neg_q ? -$signed(fpm_mag) : $signed(fpm_mag);

  // Result register, loaded once the previous beat has left.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      alt_out_q    <= alt_q;
      diff_out_q   <= gdiff_q;
      vs_out_q     <= vs_val;
      primed_out_q <= !prime_q;
    end
  end

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.div_done  = div_done;

  assign alt_out_cm_o  = alt_out_q;
  assign alt_diff_cm_o = diff_out_q;
  assign vs_fpm_o      = vs_out_q;
  assign primed_o      = primed_out_q;

endmodule

`default_nettype wire
